// ===== sv/dlr_pkg.sv =====
// ----------------------------------------------------------------------------
// dlr_pkg
// shared constants, types and state codes of the dda line rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package dlr_pkg;

  localparam int COORD_BITS   = 6;
  localparam int FRAC_BITS    = 16;
  localparam int ACC_BITS     = COORD_BITS + FRAC_BITS;
  localparam int INC_BITS     = FRAC_BITS + 2;
  localparam int QUO_BITS     = FRAC_BITS + 1;
  localparam int DIV_CNT_BITS = $clog2(FRAC_BITS);

  localparam int FIELD_BITS   = 6;
  localparam int COLOR_BITS   = 8;
  localparam int INDEX_BITS   = 12;
  localparam int WIDTH_BITS   = 7;
  localparam int IN_DATA_BITS  = 48;
  localparam int OUT_DATA_BITS = 48;

  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

  localparam logic [WIDTH_BITS-1:0] FRAME_WIDTH_RESET = WIDTH_BITS'(64);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [ACC_BITS-1:0]   acc_t;
  typedef logic [INC_BITS-1:0]   inc_t;
  typedef logic [COLOR_BITS-1:0] color_t;

  // one line command as it arrives
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    color_t red;
    color_t green;
    color_t blue;
  } cmd_t;

  // a set-up line, ready to be walked
  typedef struct packed {
    coord_t x0;
    coord_t y0;
    inc_t   x_inc;
    inc_t   y_inc;
    coord_t step;
    color_t red;
    color_t green;
    color_t blue;
  } line_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_PUSH
  } front_state_t;

endpackage

`default_nettype wire

// ===== sv/dlr_front.sv =====
// ----------------------------------------------------------------------------
// dlr_front
// accepts line commands, picks the major axis, orders the endpoints and
// divides both deltas by the major span one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire dlr_pkg::cmd_t cmd,
  output logic               push,
  output dlr_pkg::line_t     push_line,
  input  wire logic          queue_full
);

  dlr_pkg::front_state_t state, state_next;

  dlr_pkg::coord_t x0, y0, step;
  dlr_pkg::coord_t rem_x, rem_y;
  logic [dlr_pkg::QUO_BITS-1:0] quo_x, quo_y;
  logic neg_x, neg_y;
  logic [dlr_pkg::DIV_CNT_BITS-1:0] bit_cnt;
  dlr_pkg::color_t red, green, blue;

  // classification of the incoming command
  dlr_pkg::coord_t ax0, ay0, ax1, ay1, dxm, dym, astep, sx0, sy0, sx1, sy1;
  logic swap, x_major;

  always_comb begin
    ax0 = cmd.x0[dlr_pkg::COORD_BITS-1:0];
    ay0 = cmd.y0[dlr_pkg::COORD_BITS-1:0];
    ax1 = cmd.x1[dlr_pkg::COORD_BITS-1:0];
    ay1 = cmd.y1[dlr_pkg::COORD_BITS-1:0];
    dxm = (ax1 >= ax0) ? ax1 - ax0 : ax0 - ax1;
    dym = (ay1 >= ay0) ? ay1 - ay0 : ay0 - ay1;
    // tie goes to y
    x_major = dxm > dym;
    swap    = x_major ? (ax0 > ax1) : (ay0 > ay1);
    astep   = x_major ? dxm : dym;
    sx0 = swap ? ax1 : ax0;
    sy0 = swap ? ay1 : ay0;
    sx1 = swap ? ax0 : ax1;
    sy1 = swap ? ay0 : ay1;
  end

  // one restoring step for each axis
  logic [dlr_pkg::COORD_BITS:0] shx, shy, step_w;
  logic ge_x, ge_y;

  always_comb begin
    step_w = {1'b0, step};
    shx  = {rem_x, 1'b0};
    shy  = {rem_y, 1'b0};
    ge_x = shx >= step_w;
    ge_y = shy >= step_w;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dlr_pkg::FS_IDLE: if (cmd_valid) state_next = dlr_pkg::FS_DIV;
      dlr_pkg::FS_DIV:  if (bit_cnt == dlr_pkg::DIV_CNT_BITS'(dlr_pkg::FRAC_BITS - 1))
                          state_next = dlr_pkg::FS_PUSH;
      dlr_pkg::FS_PUSH: if (!queue_full) state_next = dlr_pkg::FS_IDLE;
      default:          state_next = dlr_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlr_pkg::FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == dlr_pkg::FS_IDLE && cmd_valid) begin
      x0    <= sx0;
      y0    <= sy0;
      step  <= astep;
      neg_x <= sx1 < sx0;
      neg_y <= sy1 < sy0;
      red   <= cmd.red;
      green <= cmd.green;
      blue  <= cmd.blue;
      // integer bit: the delta is never above the span
      quo_x <= dlr_pkg::QUO_BITS'(dxm >= astep);
      quo_y <= dlr_pkg::QUO_BITS'(dym >= astep);
      rem_x <= (dxm >= astep) ? dxm - astep : dxm;
      rem_y <= (dym >= astep) ? dym - astep : dym;
      bit_cnt <= '0;
    end else if (state == dlr_pkg::FS_DIV) begin
      quo_x <= {quo_x[dlr_pkg::QUO_BITS-2:0], ge_x};
      quo_y <= {quo_y[dlr_pkg::QUO_BITS-2:0], ge_y};
      rem_x <= dlr_pkg::COORD_BITS'(ge_x ? shx - step_w : shx);
      rem_y <= dlr_pkg::COORD_BITS'(ge_y ? shy - step_w : shy);
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  dlr_pkg::inc_t inc_x, inc_y;

  always_comb begin
    inc_x = dlr_pkg::INC_BITS'(quo_x);
    inc_y = dlr_pkg::INC_BITS'(quo_y);
    if (neg_x) inc_x = '0 - inc_x;
    if (neg_y) inc_y = '0 - inc_y;
    // equal endpoints: no walk
    if (step == '0) begin
      inc_x = '0;
      inc_y = '0;
    end
  end

  always_comb begin
    cmd_ready = state == dlr_pkg::FS_IDLE;
    push      = state == dlr_pkg::FS_PUSH && !queue_full;
    push_line.x0    = x0;
    push_line.y0    = y0;
    push_line.x_inc = inc_x;
    push_line.y_inc = inc_y;
    push_line.step  = step;
    push_line.red   = red;
    push_line.green = green;
    push_line.blue  = blue;
  end

endmodule

`default_nettype wire

// ===== sv/dlr_queue.sv =====
// ----------------------------------------------------------------------------
// dlr_queue
// short fifo of set-up lines between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire dlr_pkg::line_t push_line,
  output logic                full,
  input  wire logic           pop,
  output dlr_pkg::line_t      pop_line,
  output logic                empty
);

  dlr_pkg::line_t entries [dlr_pkg::QUEUE_DEPTH];
  logic [dlr_pkg::QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [dlr_pkg::QPTR_BITS:0]   fill;

  always_comb begin
    full     = fill == (dlr_pkg::QPTR_BITS + 1)'(dlr_pkg::QUEUE_DEPTH);
    empty    = fill == '0;
    pop_line = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_line;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/dlr_back.sv =====
// ----------------------------------------------------------------------------
// dlr_back
// walks one set-up line, one pixel a cycle while the output is not stalled, into the output register
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [dlr_pkg::WIDTH_BITS-1:0]  frame_width,
  input  wire dlr_pkg::line_t                  line,
  input  wire logic                            empty,
  output logic                                 pop,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [dlr_pkg::FIELD_BITS-1:0]       pixel_x,
  output logic [dlr_pkg::FIELD_BITS-1:0]       pixel_y,
  output logic [dlr_pkg::INDEX_BITS-1:0]       pixel_index,
  output dlr_pkg::color_t                      out_red,
  output dlr_pkg::color_t                      out_green,
  output dlr_pkg::color_t                      out_blue,
  output logic                                 last_pixel
);

  localparam dlr_pkg::acc_t HALF = dlr_pkg::acc_t'(1) << (dlr_pkg::FRAC_BITS - 1);

  logic            busy;
  dlr_pkg::acc_t   x_acc, y_acc, x_inc, y_inc;
  dlr_pkg::coord_t left;
  dlr_pkg::color_t red, green, blue;

  logic            advance;
  dlr_pkg::acc_t   x_rnd, y_rnd;
  dlr_pkg::coord_t px, py;
  logic [dlr_pkg::WIDTH_BITS+dlr_pkg::COORD_BITS:0] index_full;

  always_comb begin
    pop     = !busy && !empty;
    advance = busy && (!out_valid || out_ready);
    x_rnd   = x_acc + HALF;
    y_rnd   = y_acc + HALF;
    px      = x_rnd[dlr_pkg::ACC_BITS-1:dlr_pkg::FRAC_BITS];
    py      = y_rnd[dlr_pkg::ACC_BITS-1:dlr_pkg::FRAC_BITS];
    index_full = (dlr_pkg::WIDTH_BITS + dlr_pkg::COORD_BITS + 1)'(px)
               + (dlr_pkg::WIDTH_BITS + dlr_pkg::COORD_BITS + 1)'(frame_width)
               * (dlr_pkg::WIDTH_BITS + dlr_pkg::COORD_BITS + 1)'(py);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (advance && left == '0) begin
        busy <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      x_acc <= dlr_pkg::acc_t'(line.x0) << dlr_pkg::FRAC_BITS;
      y_acc <= dlr_pkg::acc_t'(line.y0) << dlr_pkg::FRAC_BITS;
      // increments sign-extend to the accumulator width
      x_inc <= dlr_pkg::acc_t'($signed(line.x_inc));
      y_inc <= dlr_pkg::acc_t'($signed(line.y_inc));
      left  <= line.step;
      red   <= line.red;
      green <= line.green;
      blue  <= line.blue;
    end else if (advance) begin
      x_acc <= x_acc + x_inc;
      y_acc <= y_acc + y_inc;
      left  <= left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_x     <= dlr_pkg::FIELD_BITS'(px);
      pixel_y     <= dlr_pkg::FIELD_BITS'(py);
      pixel_index <= index_full[dlr_pkg::INDEX_BITS-1:0];
      out_red     <= red;
      out_green   <= green;
      out_blue    <= blue;
      last_pixel  <= left == '0;
    end
  end

endmodule

`default_nettype wire

// ===== sv/dda_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// turns line commands into a stream of pixels with framebuffer index
// ----------------------------------------------------------------------------
// A line command is a request with two endpoints and a colour; the block
// answers with step+1 pixel requests, step being the larger axis span, the
// last marked with tlast. The front takes a command in its idle state, divides
// both deltas one bit per cycle (FRAC_BITS quotient bits) and then hands the
// set-up line to a two-entry queue, stalling while the queue is full; it takes
// no new command until it is back in idle. The back loads a line from the queue
// and then emits one pixel a cycle while the output is not stalled, and loads
// no new line until the last pixel of the current one has been emitted.
// ----------------------------------------------------------------------------
`default_nettype none

module dda_line_rasterizer (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [dlr_pkg::WIDTH_BITS-1:0]       cfg_wr_data,   // frame_width
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // start_x, start_y, end_x, end_y, color_red, color_green, color_blue
  input  wire logic [dlr_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // pixel_x, pixel_y, pixel_index, out_red, out_green, out_blue
  output logic [dlr_pkg::OUT_DATA_BITS-1:0]         m_axis_tdata,
  output logic                                      m_axis_tlast   // last_pixel
);

  logic [dlr_pkg::WIDTH_BITS-1:0] frame_width;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= dlr_pkg::FRAME_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      frame_width <= cfg_wr_data;
    end
  end

  dlr_pkg::cmd_t cmd;

  always_comb begin
    cmd.x0    = dlr_pkg::COORD_BITS'(s_axis_tdata[5:0]);
    cmd.y0    = dlr_pkg::COORD_BITS'(s_axis_tdata[11:6]);
    cmd.x1    = dlr_pkg::COORD_BITS'(s_axis_tdata[17:12]);
    cmd.y1    = dlr_pkg::COORD_BITS'(s_axis_tdata[23:18]);
    cmd.red   = s_axis_tdata[31:24];
    cmd.green = s_axis_tdata[39:32];
    cmd.blue  = s_axis_tdata[47:40];
  end

  logic           push, pop, full, empty;
  dlr_pkg::line_t push_line, pop_line;

  dlr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (s_axis_tvalid),
    .cmd_ready  (s_axis_tready),
    .cmd        (cmd),
    .push       (push),
    .push_line  (push_line),
    .queue_full (full)
  );

  dlr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_line (push_line),
    .full      (full),
    .pop       (pop),
    .pop_line  (pop_line),
    .empty     (empty)
  );

  logic [dlr_pkg::FIELD_BITS-1:0] pixel_x, pixel_y;
  logic [dlr_pkg::INDEX_BITS-1:0] pixel_index;
  dlr_pkg::color_t                out_red, out_green, out_blue;

  dlr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_width (frame_width),
    .line        (pop_line),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_index (pixel_index),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .last_pixel  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_blue, out_green, out_red, pixel_index, pixel_y, pixel_x};

endmodule

`default_nettype wire

// ===== sv/dlr_checker.sv =====
// ----------------------------------------------------------------------------
// dlr_checker
// port-level checks of the pixel stream, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [47:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  logic [5:0] cur_x, cur_y;

  assign cur_x = m_axis_tdata[5:0];
  assign cur_y = m_axis_tdata[11:6];

  // stalled pixel holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled pixel changed");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("pixel valid right after reset");

  // a line keeps streaming with one colour until its last pixel
  a_line_runs: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tdata[47:24] == $past(m_axis_tdata[47:24]))
    else $error("line broke off or changed colour");

  // neighboring pixels of a line touch
  a_step: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      (cur_x == $past(cur_x) || cur_x == $past(cur_x) + 6'd1 ||
       cur_x == $past(cur_x) - 6'd1) &&
      (cur_y == $past(cur_y) || cur_y == $past(cur_y) + 6'd1 ||
       cur_y == $past(cur_y) - 6'd1))
    else $error("pixel step larger than one");

endmodule

bind dda_line_rasterizer dlr_checker u_dlr_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== tb/tb_dda_line_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dda_line_rasterizer
// self-checking bench for the dda line rasterizer
// ----------------------------------------------------------------------------
// Line command requests go in on the slave stream. Each accepted command is
// walked in fixed point by a model of the block, which queues the pixels the
// block has to emit. Every pixel request on the master stream is compared
// with the oldest queued pixel. Both streams idle at random, the receiver
// holds off for a long stretch once so that the block fills up, and the
// frame width is changed between phases while the block is idle.
// ----------------------------------------------------------------------------

import dlr_pkg::*;

typedef struct packed {
  coord_t x0;
  coord_t y0;
  coord_t x1;
  coord_t y1;
  color_t red;
  color_t green;
  color_t blue;
} line_cmd_t;

typedef struct packed {
  coord_t                x;
  coord_t                y;
  logic [INDEX_BITS-1:0] index;
  color_t                red;
  color_t                green;
  color_t                blue;
  logic                  last;
} pixel_t;

class raster_scoreboard;
  logic [WIDTH_BITS-1:0] frame_width;
  pixel_t                pending_pixels[$];
  int                    mismatches;

  function new();
    frame_width = FRAME_WIDTH_RESET;
    mismatches  = 0;
  endfunction

  function int pending();
    return pending_pixels.size();
  endfunction

  // signed delta over span, truncated toward zero, as a Q1.FRAC increment
  function inc_t slope_inc(int mag, bit neg, int span);
    int   q;
    inc_t v;
    if (span == 0) return '0;
    q = (mag << FRAC_BITS) / span;
    v = q[INC_BITS-1:0];
    if (neg) v = -v;
    return v;
  endfunction

  // walk one line command and queue the pixels it gives
  function void plot_line(line_cmd_t c);
    int     ax0, ay0, ax1, ay1, t, dxm, dym, span, px, py, idx;
    bit     swap;
    inc_t   xinc, yinc;
    acc_t   xacc, yacc, xstep, ystep, half, xr, yr;
    pixel_t p;
    ax0 = c.x0;
    ay0 = c.y0;
    ax1 = c.x1;
    ay1 = c.y1;
    dxm = (ax1 >= ax0) ? ax1 - ax0 : ax0 - ax1;
    dym = (ay1 >= ay0) ? ay1 - ay0 : ay0 - ay1;
    // tie goes to y as major axis
    swap = (dxm > dym) ? (ax0 > ax1) : (ay0 > ay1);
    if (swap) begin
      t = ax0; ax0 = ax1; ax1 = t;
      t = ay0; ay0 = ay1; ay1 = t;
    end
    span = (dxm > dym) ? dxm : dym;
    xinc = slope_inc(dxm, ax1 < ax0, span);
    yinc = slope_inc(dym, ay1 < ay0, span);
    xstep = {{(ACC_BITS-INC_BITS){xinc[INC_BITS-1]}}, xinc};
    ystep = {{(ACC_BITS-INC_BITS){yinc[INC_BITS-1]}}, yinc};
    xacc = acc_t'(ax0) << FRAC_BITS;
    yacc = acc_t'(ay0) << FRAC_BITS;
    half = acc_t'(1) << (FRAC_BITS - 1);
    for (int n = 0; n <= span; n++) begin
      // round half up, wrapping within the accumulator width
      xr = xacc + half;
      yr = yacc + half;
      px = xr[ACC_BITS-1:FRAC_BITS];
      py = yr[ACC_BITS-1:FRAC_BITS];
      idx = px + frame_width * py;
      p.x     = px[COORD_BITS-1:0];
      p.y     = py[COORD_BITS-1:0];
      p.index = idx[INDEX_BITS-1:0];
      p.red   = c.red;
      p.green = c.green;
      p.blue  = c.blue;
      p.last  = (n == span);
      pending_pixels.push_back(p);
      xacc = xacc + xstep;
      yacc = yacc + ystep;
    end
  endfunction

  function void check_pixel(logic [OUT_DATA_BITS-1:0] data, logic last);
    pixel_t got, want;
    got.x     = data[5:0];
    got.y     = data[11:6];
    got.index = data[23:12];
    got.red   = data[31:24];
    got.green = data[39:32];
    got.blue  = data[47:40];
    got.last  = last;
    if (pending_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected pixel: x=%0d y=%0d idx=%0d rgb=%h%h%h last=%0b",
                 got.x, got.y, got.index, got.red, got.green, got.blue, got.last);
      return;
    end
    want = pending_pixels.pop_front();
    if (got.x !== want.x || got.y !== want.y || got.index !== want.index ||
        got.red !== want.red || got.green !== want.green ||
        got.blue !== want.blue || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("pixel mismatch: exp x=%0d y=%0d idx=%0d rgb=%h%h%h last=%0b",
                 want.x, want.y, want.index, want.red, want.green, want.blue,
                 want.last);
        $display("                got x=%0d y=%0d idx=%0d rgb=%h%h%h last=%0b",
                 got.x, got.y, got.index, got.red, got.green, got.blue, got.last);
      end
    end
  endfunction
endclass

module tb_dda_line_rasterizer;

  localparam int STALL_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 32;
  localparam int PHASE_COUNT   = 6;
  localparam int HOLD_CYCLES   = 500;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [WIDTH_BITS-1:0]    cfg_wr_data = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tlast;

  raster_scoreboard sb;
  bit               tx_idle = 1'b1;
  bit               rx_idle = 1'b1;
  int               rx_hold = 0;
  int               idle_cycles = 0;

  always #5 clk = ~clk;

  dda_line_rasterizer u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : ((v > 63) ? 63 : v);
  endfunction

  function automatic line_cmd_t make_line(int x0, int y0, int x1, int y1,
                                          int r, int g, int b);
    line_cmd_t c;
    c.x0    = x0[5:0];
    c.y0    = y0[5:0];
    c.x1    = x1[5:0];
    c.y1    = y1[5:0];
    c.red   = r[7:0];
    c.green = g[7:0];
    c.blue  = b[7:0];
    return c;
  endfunction

  function automatic line_cmd_t rand_line();
    int kind, d, x0, y0, x1, y1;
    kind = $urandom_range(0, 9);
    x0 = $urandom_range(0, 63);
    y0 = $urandom_range(0, 63);
    x1 = $urandom_range(0, 63);
    y1 = $urandom_range(0, 63);
    case (kind)
      0: begin
        x1 = x0;
        y1 = y0;
      end
      1: y1 = y0;
      2: x1 = x0;
      3: begin
        // exact diagonal, either direction on each axis
        d  = $urandom_range(0, 63);
        x0 = $urandom_range(0, 63 - d);
        y0 = $urandom_range(0, 63 - d);
        x1 = x0 + d;
        y1 = y0 + d;
        if ($urandom_range(0, 1)) begin
          x0 = x1;
          x1 = x1 - d;
        end
        if ($urandom_range(0, 1)) begin
          y0 = y1;
          y1 = y1 - d;
        end
      end
      4, 5: begin
        x1 = clamp_coord(x0 + $urandom_range(0, 8) - 4);
        y1 = clamp_coord(y0 + $urandom_range(0, 8) - 4);
      end
      default: ;
    endcase
    return make_line(x0, y0, x1, y1, $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255));
  endfunction

  task automatic send_line(line_cmd_t c, bit no_gap);
    int gap;
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {c.blue, c.green, c.red, c.y1, c.x1, c.y0, c.x0};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.plot_line(c);
    gap = (no_gap || !tx_idle) ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_frame_width(int w);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = w[WIDTH_BITS-1:0];
    sb.frame_width = w[WIDTH_BITS-1:0];
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // stimulus
  initial begin
    int widths[PHASE_COUNT];
    int burst;
    sb = new();
    widths[0] = 1;
    widths[1] = 127;
    widths[2] = 0;
    widths[3] = 64;
    widths[4] = $urandom_range(2, 126);
    widths[5] = $urandom_range(1, 64);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed lines at the reset frame width
    send_line(make_line(0, 0, 0, 0, 8'h00, 8'h00, 8'h00), 1'b0);
    send_line(make_line(63, 63, 63, 63, 8'hff, 8'hff, 8'hff), 1'b0);
    send_line(make_line(0, 0, 63, 0, 8'ha5, 8'h5a, 8'hc3), 1'b0);
    send_line(make_line(63, 5, 0, 5, 8'h5a, 8'ha5, 8'h3c), 1'b0);
    send_line(make_line(7, 0, 7, 63, 8'h01, 8'h80, 8'hfe), 1'b0);
    send_line(make_line(9, 63, 9, 0, 8'h7f, 8'h02, 8'h40), 1'b0);
    // equal spans: y is the major axis
    send_line(make_line(0, 0, 63, 63, 8'h12, 8'h34, 8'h56), 1'b0);
    send_line(make_line(63, 0, 0, 63, 8'h9a, 8'hbc, 8'hde), 1'b0);
    send_line(make_line(0, 63, 63, 0, 8'hf0, 8'h0f, 8'h55), 1'b0);
    // half-way rounding
    send_line(make_line(0, 0, 2, 1, 8'haa, 8'h55, 8'hff), 1'b0);
    send_line(make_line(0, 0, 1, 2, 8'h55, 8'haa, 8'h00), 1'b0);
    send_line(make_line(4, 3, 1, 2, 8'h11, 8'h22, 8'h33), 1'b0);
    send_line(make_line(10, 20, 50, 23, 8'h44, 8'h88, 8'hcc), 1'b0);
    send_line(make_line(50, 10, 47, 60, 8'hcc, 8'h88, 8'h44), 1'b0);
    send_line(make_line(63, 63, 0, 62, 8'h08, 8'h10, 8'h20), 1'b0);
    send_line(make_line(32, 32, 31, 31, 8'h80, 8'h40, 8'h01), 1'b0);
    send_line(make_line(0, 63, 63, 63, 8'hfe, 8'h7f, 8'h80), 1'b0);
    send_line(make_line(1, 62, 62, 1, 8'h3c, 8'hc3, 8'h99), 1'b0);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      wait_drained();
      write_frame_width(widths[ph]);
      tx_idle = (ph != 3);
      rx_idle = (ph != 3);
      burst = 0;
      if (ph == 2) begin
        // receiver blocks while commands keep coming back to back
        rx_hold = HOLD_CYCLES;
        burst = 12;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_line(rand_line(), burst > 0);
        if (burst > 0) burst--;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("PASS dda_line_rasterizer");
    else
      $display("FAIL dda_line_rasterizer");
    $finish;
  end

  // pixel receiver
  initial begin
    int stall_left;
    stall_left = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold > 0) begin
        m_axis_tready = 1'b0;
        rx_hold--;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (rx_idle && $urandom_range(0, 99) < 20)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                   : $urandom_range(1, 3);
      end
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_pixel(m_axis_tdata, m_axis_tlast);
      @(negedge clk);
    end
  end

  // no handshake on either side for too long ends the run
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL dda_line_rasterizer");
        $finish;
      end
    end
  end

endmodule

// ===== sim.f =====
sv/dlr_pkg.sv
sv/dlr_front.sv
sv/dlr_queue.sv
sv/dlr_back.sv
sv/dda_line_rasterizer.sv
sv/dlr_checker.sv
tb/tb_dda_line_rasterizer.sv
